@@ rtl/ptt_pkg.sv @@
package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int TID_W    = 4;
  localparam int PERIOD_W = 32;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int ACNT_W   = 5;

  localparam int S_TDATA_W = ((TID_W + PERIOD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((1 + SLOT_W + ACNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EMIT_ADD_OK   = 3'd0,
    EMIT_ADD_FAIL = 3'd1,
    EMIT_REMOVE   = 3'd2,
    EMIT_FIRED    = 3'd3,
    EMIT_DONE     = 3'd4
  } emit_e;

  typedef struct packed {
    logic  accept;
    logic  idx_clr;
    logic  idx_inc;
    logic  mem_rd;
    logic  tick_inc;
    logic  emit;
    emit_e emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  period_zero;
    logic  full;
    logic  slot_free;
    logic  idx_last;
    logic  due;
    logic  out_free;
  } dp_status_t;

endpackage

@@ rtl/periodic_task_tick_table.sv @@
// Periodic task tick table: 16 task slots (NUM_SLOTS) with period and next-due
// time, a 32-bit tick counter advanced by each tick item and an active-slot count.
// Input stream: tuser = mode (add, remove, tick); tdata = task_id, period.
// Output stream: tuser = kind; tdata = ok, slot, active_count; tlast marks the
// final result of an input item. Add and remove give one reply; a tick gives
// one fired item per due slot in slot order, then a tick-done item.
// One item is handled at a time; tready is high only while the sequencer idles.
// An add searches upward from slot 0 for the lowest free slot; a zero period or
// a full table rejects it. A tick evaluates one slot per cycle out of the slot
// memory, whose read is registered, unless a due slot waits for room in the
// output register.
// A stalled receiver holds the output register; the scan then waits on the
// slot that is due until the pending result is taken, and nothing is lost.
// Reset clears the tick counter, the active marks and the count; the slot
// memory needs no clearing since an inactive slot's entry is never used.
module periodic_task_tick_table import ptt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // task_id[3:0], period[35:4], zero
  input  logic [MODE_W-1:0]    s_axis_tuser_i,  // mode[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // ok[0], slot[4:1], active_count[9:5], zero
  output logic [KIND_W-1:0]    m_axis_tuser_o,  // kind[1:0]
  output logic                 m_axis_tlast_o
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic              ok;
  logic [SLOT_W-1:0] slot;
  logic [ACNT_W-1:0] acnt;

  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (s_axis_tuser_i),
    .task_id_i      (s_axis_tdata_i[TID_W-1:0]),
    .period_i       (s_axis_tdata_i[TID_W+PERIOD_W-1:TID_W]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .kind_o         (m_axis_tuser_o),
    .ok_o           (ok),
    .slot_o         (slot),
    .active_count_o (acnt),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - 1 - SLOT_W - ACNT_W){1'b0}}, acnt, slot, ok};

endmodule

@@ rtl/ptt_dp.sv @@
module ptt_dp import ptt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [TID_W-1:0]    task_id_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   kind_o,
  output logic                ok_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [ACNT_W-1:0]   active_count_o,
  output logic                last_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = 2 * PERIOD_W;

  mode_e                 mode_q;
  logic [TID_W-1:0]      tid_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [PERIOD_W-1:0]   now_q, now_d;
  logic [NUM_SLOTS-1:0]  active_q, active_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [ENT_W-1:0]      mem_q [NUM_SLOTS];
  logic [PERIOD_W-1:0]   rd_period_q, rd_due_q;

  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic                  ok_q, ok_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [ACNT_W-1:0]     acnt_q, acnt_d;
  logic                  last_q, last_d;

  logic [IDX_W+TID_W-1:0]  tid_ext;
  logic [IDX_W-1:0]        tid_idx;
  logic                    tid_in_range;
  logic                    rem_ok;
  logic                    due;
  logic                    out_free;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [ENT_W-1:0]        mem_wdata;
  logic [SLOT_W+IDX_W-1:0] idx_ext;
  logic [ACNT_W+CNT_W-1:0] cnt_ext;
  logic                    add_commit, rem_commit;

  assign tid_ext      = {{IDX_W{1'b0}}, tid_q};
  assign tid_idx      = tid_ext[IDX_W-1:0];
  assign tid_in_range = tid_ext < (IDX_W + TID_W)'(NUM_SLOTS);
  assign rem_ok       = tid_in_range && active_q[tid_idx];
  assign due          = active_q[idx_q] && (now_q >= rd_due_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign idx_ext      = {{SLOT_W{1'b0}}, idx_q};

  assign add_commit = cmd_i.emit && (cmd_i.emit_sel == EMIT_ADD_OK);
  assign rem_commit = cmd_i.emit && (cmd_i.emit_sel == EMIT_REMOVE) && rem_ok;
  assign mem_we     = add_commit || (cmd_i.emit && (cmd_i.emit_sel == EMIT_FIRED));
  assign mem_wdata  = add_commit ? {period_q, now_q + period_q}
                                 : {rd_period_q, rd_due_q + rd_period_q};
  assign rd_addr    = cmd_i.idx_inc ? idx_q + IDX_W'(1) : idx_q;

  assign status_o.mode        = mode_q;
  assign status_o.period_zero = (period_q == '0);
  assign status_o.full        = (cnt_q == CNT_W'(NUM_SLOTS));
  assign status_o.slot_free   = !active_q[idx_q];
  assign status_o.idx_last    = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign status_o.due         = due;
  assign status_o.out_free    = out_free;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (add_commit) begin
      active_d[idx_q] = 1'b1;
      cnt_d           = cnt_q + CNT_W'(1);
    end
    if (rem_commit) begin
      active_d[tid_idx] = 1'b0;
      cnt_d             = cnt_q - CNT_W'(1);
    end
  end

  assign cnt_ext = {{ACNT_W{1'b0}}, cnt_d};
  assign now_d   = cmd_i.tick_inc ? now_q + PERIOD_W'(1) : now_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    kind_d = kind_q;
    ok_d   = ok_q;
    slot_d = slot_q;
    acnt_d = acnt_q;
    last_d = last_q;
    if (cmd_i.emit) begin
      acnt_d = cnt_ext[ACNT_W-1:0];
      case (cmd_i.emit_sel)
        EMIT_ADD_OK: begin
          kind_d = KIND_ADD;
          ok_d   = 1'b1;
          slot_d = idx_ext[SLOT_W-1:0];
          last_d = 1'b1;
        end
        EMIT_ADD_FAIL: begin
          kind_d = KIND_ADD;
          ok_d   = 1'b0;
          slot_d = '0;
          last_d = 1'b1;
        end
        EMIT_REMOVE: begin
          kind_d = KIND_REMOVE;
          ok_d   = rem_ok;
          slot_d = tid_q;
          last_d = 1'b1;
        end
        EMIT_FIRED: begin
          kind_d = KIND_FIRED;
          ok_d   = 1'b0;
          slot_d = idx_ext[SLOT_W-1:0];
          last_d = 1'b0;
        end
        default: begin
          kind_d = KIND_DONE;
          ok_d   = 1'b0;
          slot_d = '0;
          last_d = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      active_q    <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      now_q       <= now_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_e'(mode_i);
      tid_q    <= task_id_i;
      period_q <= period_i;
    end
    kind_q <= kind_d;
    ok_q   <= ok_d;
    slot_q <= slot_d;
    acnt_q <= acnt_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      {rd_period_q, rd_due_q} <= mem_q[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign ok_o           = ok_q;
  assign slot_o         = slot_q;
  assign active_count_o = acnt_q;
  assign last_o         = last_q;

  a_cnt_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(active_q)))
    else $error("active count out of step with active marks");

  a_add_to_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_commit |-> !active_q[idx_q])
    else $error("add placed into an occupied slot");

  a_fire_only_when_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.emit_sel == EMIT_FIRED)) |-> due)
    else $error("fired item for a slot that is not due");

endmodule

@@ rtl/ptt_ctrl.sv @@
module ptt_ctrl import ptt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DISP      = 6'b000010,
    S_ADD_SRCH  = 6'b000100,
    S_TICK_RD   = 6'b001000,
    S_TICK_EV   = 6'b010000,
    S_TICK_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        case (status_i.mode)
          MODE_ADD: begin
            if (status_i.period_zero || status_i.full) begin
              if (status_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_ADD_FAIL;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_ADD_SRCH;
            end
          end
          MODE_REMOVE: begin
            if (status_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = EMIT_REMOVE;
              state_d        = S_IDLE;
            end
          end
          MODE_TICK: begin
            cmd_o.tick_inc = 1'b1;
            cmd_o.idx_clr  = 1'b1;
            state_d        = S_TICK_RD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ADD_SRCH: begin
        if (status_i.slot_free) begin
          if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_ADD_OK;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TICK_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_TICK_EV;
      end
      S_TICK_EV: begin
        if (!status_i.due || status_i.out_free) begin
          if (status_i.due) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_FIRED;
          end
          if (status_i.idx_last) begin
            state_d = S_TICK_DONE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            cmd_o.mem_rd  = 1'b1;
          end
        end
      end
      S_TICK_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_DONE;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result issued while output register is occupied");

  a_accept_dispatches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_DISP))
    else $error("accepted item not dispatched");

endmodule

@@ bench/tick_table_checker.sv @@
`timescale 1ns / 100ps

module tick_table_checker import ptt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [MODE_W-1:0]    s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,
  input  logic [KIND_W-1:0]    m_axis_tuser_i,
  input  logic                 m_axis_tlast_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   items_o,
  output int                   results_o,
  output int                   firings_o
);

  typedef struct {
    kind_e             kind;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ACNT_W-1:0] acnt;
    logic              last;
  } sched_reply_t;

  logic [PERIOD_W-1:0] now_ticks;
  logic                slot_busy  [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_every [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_due   [NUM_SLOTS];
  logic [ACNT_W-1:0]   busy_total;
  sched_reply_t        awaited_q[$];
  int                  mismatches, items, results, firings;

  function automatic void queue_reply(kind_e kind, logic ok, int slot, logic last);
    sched_reply_t r;
    r.kind = kind;
    r.ok   = ok;
    r.slot = slot[SLOT_W-1:0];
    r.acnt = busy_total;
    r.last = last;
    awaited_q.push_back(r);
  endfunction

  function automatic void apply_request(logic [MODE_W-1:0] mode, logic [TID_W-1:0] tid,
                                        logic [PERIOD_W-1:0] period);
    int free_idx;
    free_idx = -1;
    case (mode)
      MODE_ADD: begin
        if (period != '0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_busy[i] && free_idx < 0) free_idx = i;
          end
        end
        if (free_idx >= 0) begin
          slot_busy[free_idx]  = 1'b1;
          slot_every[free_idx] = period;
          slot_due[free_idx]   = now_ticks + period;
          busy_total           = busy_total + ACNT_W'(1);
          queue_reply(KIND_ADD, 1'b1, free_idx, 1'b1);
        end else begin
          queue_reply(KIND_ADD, 1'b0, 0, 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (int'(tid) < NUM_SLOTS && slot_busy[tid]) begin
          slot_busy[tid]  = 1'b0;
          slot_every[tid] = '0;
          slot_due[tid]   = '0;
          busy_total      = busy_total - ACNT_W'(1);
          queue_reply(KIND_REMOVE, 1'b1, int'(tid), 1'b1);
        end else begin
          queue_reply(KIND_REMOVE, 1'b0, int'(tid), 1'b1);
        end
      end
      MODE_TICK: begin
        now_ticks = now_ticks + PERIOD_W'(1);
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i] && now_ticks >= slot_due[i]) begin
            slot_due[i] = slot_due[i] + slot_every[i];
            firings++;
            queue_reply(KIND_FIRED, 1'b0, i, 1'b0);
          end
        end
        queue_reply(KIND_DONE, 1'b0, 0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_reply_t      want;
    logic              got_ok;
    logic [SLOT_W-1:0] got_slot;
    logic [ACNT_W-1:0] got_acnt;
    if (!rst_ni) begin
      now_ticks  = '0;
      busy_total = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_busy[i]  = 1'b0;
        slot_every[i] = '0;
        slot_due[i]   = '0;
      end
      awaited_q.delete();
      mismatches = 0;
      items      = 0;
      results    = 0;
      firings    = 0;
    end else begin
      // results first: none can belong to an item accepted at this same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results++;
        got_ok   = m_axis_tdata_i[0];
        got_slot = m_axis_tdata_i[SLOT_W:1];
        got_acnt = m_axis_tdata_i[SLOT_W+ACNT_W:SLOT_W+1];
        if (awaited_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result kind %0d ok %0d slot %0d count %0d last %0d",
                     $time, m_axis_tuser_i, got_ok, got_slot, got_acnt, m_axis_tlast_i);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (want.kind != m_axis_tuser_i || want.ok != got_ok || want.slot != got_slot ||
              want.acnt != got_acnt || want.last != m_axis_tlast_i) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch, exp kind %0d ok %0d slot %0d count %0d last %0d",
                       $time, want.kind, want.ok, want.slot, want.acnt, want.last);
              $display("%0t:                  got kind %0d ok %0d slot %0d count %0d last %0d",
                       $time, m_axis_tuser_i, got_ok, got_slot, got_acnt, m_axis_tlast_i);
            end
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        items++;
        apply_request(s_axis_tuser_i, s_axis_tdata_i[TID_W-1:0],
                      s_axis_tdata_i[TID_W+PERIOD_W-1:TID_W]);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= awaited_q.size();
    items_o      <= items;
    results_o    <= results;
    firings_o    <= firings;
  end

endmodule

@@ bench/tb_periodic_task_tick_table.sv @@
`timescale 1ns / 100ps

module tb_periodic_task_tick_table;
  import ptt_pkg::*;

  localparam int          RANDOM_ITEMS = 450;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [MODE_W-1:0]    s_user = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;
  logic [KIND_W-1:0]    m_user;
  logic                 m_last;

  logic idle_en = 1'b1;
  logic rx_hold = 1'b0;
  logic rand_phase = 1'b0;
  int   cycle_cnt = 0;
  int   mismatches, pending, items, results, firings;

  periodic_task_tick_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  tick_table_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .items_o         (items),
    .results_o       (results),
    .firings_o       (firings)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_periodic_task_tick_table failed");
      $finish;
    end
  end

  task automatic send_item(logic [MODE_W-1:0] mode, logic [TID_W-1:0] tid,
                           logic [PERIOD_W-1:0] period);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {{(S_TDATA_W-TID_W-PERIOD_W){1'b0}}, period, tid};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // receiver: random gap per item, plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = idle_en ? $urandom_range(0, 5) : 0;
      if (gap > 0 || rx_hold) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
    end
  end

  initial begin
    wait (rand_phase);
    repeat ($urandom_range(50, 300)) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int                  sel;
    logic [PERIOD_W-1:0] period;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero period, extremes of period, removes, unused mode
    send_item(MODE_ADD, 4'hf, '0);
    send_item(MODE_ADD, 4'h0, 32'd1);
    send_item(MODE_ADD, 4'h5, '1);
    send_item(MODE_ADD, 4'ha, 32'd2);
    send_item(MODE_TICK, 4'hf, '1);
    send_item(MODE_TICK, 4'h0, '0);
    send_item(MODE_REMOVE, 4'h1, 32'h8000_0001);
    send_item(MODE_REMOVE, 4'h1, '0);
    send_item(MODE_REMOVE, 4'hf, '1);
    send_item(MODE_UNUSED, 4'h3, 32'd7);
    send_item(MODE_TICK, 4'h6, 32'h5555_aaaa);
    // fill the table, then one add too many
    for (int i = 0; i < 14; i++) send_item(MODE_ADD, i[TID_W-1:0], 32'd3);
    send_item(MODE_ADD, 4'h0, 32'd4);

    rand_phase = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = ((n / 60) % 3) != 2;
      sel = $urandom_range(0, 99);
      period = $urandom();
      if (sel < 25) begin
        case ($urandom_range(0, 9))
          0:       period = '0;
          1, 2:    period = $urandom();
          3:       period = 32'hffff_ffff - $urandom_range(0, 40);
          default: period = $urandom_range(1, 8);
        endcase
        send_item(MODE_ADD, TID_W'($urandom_range(0, 15)), period);
      end else if (sel < 50) begin
        send_item(MODE_REMOVE, TID_W'($urandom_range(0, 15)), period);
      end else if (sel < 97) begin
        send_item(MODE_TICK, TID_W'($urandom_range(0, 15)), period);
      end else begin
        send_item(MODE_UNUSED, TID_W'($urandom_range(0, 15)), period);
      end
    end
    s_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("run covered %0d items, %0d results, %0d slot firings", items, results, firings);
    $display("incl. rejected and wrapping adds, removes of idle slots and a full table");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_periodic_task_tick_table passed");
    end else begin
      $display("tb_periodic_task_tick_table failed");
    end
    $finish;
  end

endmodule
